@@ sv/assert_macros.svh @@
// Assertion macros shared by the speedometer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define PPS_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("speedometer assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define PPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("speedometer assertion failed");

`endif

@@ sv/pps_pkg.sv @@
// Types, constants and segment decode for the pulse period speedometer.
`default_nettype none
package pps_pkg;

  localparam int COUNT_WIDTH_DEF = 8;
  localparam int NUM_W           = 24;
  localparam int NUM_FRAC        = 6;
  localparam int DIVIDEND_W      = NUM_W - NUM_FRAC;
  localparam int SPEED_W         = 10;
  localparam logic [SPEED_W-1:0] SPEED_LIMIT = 10'd999;
  localparam logic [NUM_W-1:0]   NUM_RESET   = 24'd94275;

  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic kind;
    logic sensor_level;
  } pps_in_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_kmh;
    logic [7:0]         seg_hundreds;
    logic [7:0]         seg_tens;
    logic [7:0]         seg_ones;
    logic               speed_updated;
  } pps_out_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DIV    = 5'b00010,
    ST_FIN    = 5'b00100,
    ST_CONV   = 5'b01000,
    ST_RESULT = 5'b10000
  } pps_state_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic div_finish;
    logic conv_step;
    logic load_out;
  } pps_cmd_t;

  typedef struct packed {
    logic fall_seen;
    logic div_last;
    logic conv_done;
    logic out_busy;
  } pps_status_t;

  function automatic logic [7:0] seg7(input logic [3:0] digit);
    logic [7:0] pat;
    unique case (digit)
      4'd0:    pat = 8'b11000000;
      4'd1:    pat = 8'b11111001;
      4'd2:    pat = 8'b10100100;
      4'd3:    pat = 8'b10110000;
      4'd4:    pat = 8'b10011001;
      4'd5:    pat = 8'b10010010;
      4'd6:    pat = 8'b10000010;
      4'd7:    pat = 8'b11111000;
      4'd8:    pat = 8'b10000000;
      4'd9:    pat = 8'b10010000;
      default: pat = 8'hFF;
    endcase
    return pat;
  endfunction

endpackage
`default_nettype wire

@@ sv/pps_ctrl.sv @@
// Sequencing state machine for the speedometer.
`default_nettype none
`include "assert_macros.svh"
module pps_ctrl
  import pps_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  pps_status_t status,
  output pps_cmd_t    cmd
);

  pps_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = status.fall_seen ? ST_DIV : ST_RESULT;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.div_finish = 1'b1;
        state_nxt      = ST_CONV;
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        if (status.conv_done) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `PPS_ASSERT_NEXT(a_div_holds, clk, rst_n, state_r == ST_DIV && !status.div_last, state_r == ST_DIV)
  `PPS_ASSERT_NEXT(a_fall_to_div, clk, rst_n, cmd.accept && status.fall_seen, state_r == ST_DIV)

endmodule
`default_nettype wire

@@ sv/pps_dp.sv @@
// Period counter, restoring divider, digit split and output register.
`default_nettype none
`include "assert_macros.svh"
module pps_dp
  import pps_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              cfg_we,
  input  wire  [NUM_W-1:0] cfg_data,
  input  pps_in_t          in_data,
  input  pps_cmd_t         cmd,
  output pps_status_t      status,
  output logic             out_valid,
  input  wire              out_stall,
  output pps_out_t         out_data
);

  localparam int STEP_W = $clog2(DIVIDEND_W);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [NUM_W-1:0]       num_r;
  logic [COUNT_WIDTH-1:0] count_r;
  logic                   counting_r;
  logic                   last_level_r;
  logic [SPEED_W-1:0]     speed_r;
  logic                   upd_r;
  logic [3:0]             hund_r, tens_r, ones_r;
  logic [SPEED_W-1:0]     work_r;
  logic [COUNT_WIDTH-1:0] divisor_r;
  logic [COUNT_WIDTH-1:0] rem_r;
  logic [DIVIDEND_W-1:0]  quo_r;
  logic [STEP_W-1:0]      step_r;
  logic                   out_valid_r;
  pps_out_t               out_data_r;

  logic [COUNT_WIDTH:0]   trial;
  logic                   trial_ge;
  logic [SPEED_W-1:0]     speed_calc;

  assign status.fall_seen = (in_data.kind == KIND_SAMPLE) && last_level_r
                            && !in_data.sensor_level;
  assign status.div_last  = (step_r == STEP_W'(DIVIDEND_W - 1));
  assign status.conv_done = (work_r < SPEED_W'(10));
  assign status.out_busy  = out_valid_r && out_stall;

  assign trial    = {rem_r, quo_r[DIVIDEND_W-1]};
  assign trial_ge = (trial >= {1'b0, divisor_r});

  always_comb begin
    if (divisor_r == COUNT_MAX) begin
      speed_calc = '0;
    end else if (divisor_r == '0) begin
      speed_calc = SPEED_LIMIT;
    end else if (quo_r > DIVIDEND_W'(SPEED_LIMIT)) begin
      speed_calc = SPEED_LIMIT;
    end else begin
      speed_calc = quo_r[SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r        <= NUM_RESET;
      count_r      <= COUNT_MAX;
      counting_r   <= 1'b0;
      last_level_r <= 1'b1;
      speed_r      <= '0;
      upd_r        <= 1'b0;
      hund_r       <= '0;
      tens_r       <= '0;
      ones_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) num_r <= cfg_data;

      if (cmd.accept) begin
        upd_r <= 1'b0;
        if (in_data.kind == KIND_TICK) begin
          if (counting_r) begin
            if (count_r == COUNT_MAX) begin
              counting_r <= 1'b0;
              speed_r    <= '0;
              hund_r     <= '0;
              tens_r     <= '0;
              ones_r     <= '0;
              upd_r      <= 1'b1;
            end else begin
              count_r <= count_r + COUNT_WIDTH'(1);
            end
          end
        end else begin
          last_level_r <= in_data.sensor_level;
          if (status.fall_seen) begin
            count_r    <= '0;
            counting_r <= 1'b1;
            upd_r      <= 1'b1;
          end
        end
      end

      if (cmd.div_finish) begin
        speed_r <= speed_calc;
        hund_r  <= '0;
        tens_r  <= '0;
        ones_r  <= '0;
      end

      if (cmd.conv_step) begin
        if (work_r >= SPEED_W'(100)) begin
          hund_r <= hund_r + 4'd1;
        end else if (work_r >= SPEED_W'(10)) begin
          tens_r <= tens_r + 4'd1;
        end else begin
          ones_r <= work_r[3:0];
        end
      end

      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && status.fall_seen) begin
      divisor_r <= count_r;
      rem_r     <= '0;
      quo_r     <= num_r[NUM_W-1:NUM_FRAC];
      step_r    <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= trial_ge ? trial[COUNT_WIDTH-1:0] - divisor_r : trial[COUNT_WIDTH-1:0];
      quo_r  <= {quo_r[DIVIDEND_W-2:0], trial_ge};
      step_r <= step_r + STEP_W'(1);
    end
    if (cmd.div_finish) begin
      work_r <= speed_calc;
    end else if (cmd.conv_step) begin
      if (work_r >= SPEED_W'(100)) begin
        work_r <= work_r - SPEED_W'(100);
      end else if (work_r >= SPEED_W'(10)) begin
        work_r <= work_r - SPEED_W'(10);
      end
    end
    if (cmd.load_out) begin
      out_data_r.speed_kmh     <= speed_r;
      out_data_r.seg_hundreds  <= seg7(hund_r);
      out_data_r.seg_tens      <= seg7(tens_r);
      out_data_r.seg_ones      <= seg7(ones_r);
      out_data_r.speed_updated <= upd_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PPS_ASSERT_ALWAYS(a_speed_range, clk, rst_n, speed_r <= SPEED_LIMIT)
  `PPS_ASSERT_ALWAYS(a_stopped_at_max, clk, rst_n, counting_r || (count_r == COUNT_MAX))

endmodule
`default_nettype wire

@@ sv/pulse_period_speedometer.sv @@
// Top level of the pulse period speedometer.
// Each transaction is a counter tick or a sensor level sample and gives one result with the
// speed in km/h (0 to 999) and active-low PGFEDCBA patterns of its three digits. A tick or a
// sample without a falling edge goes from acceptance through the result state to the output
// register. A falling edge runs a restoring divider (one quotient bit per cycle, numerator/64
// over the held period count), then a saturation step, then the digit split that subtracts
// hundreds and tens one at a time. One item is processed at a time; the next is taken while
// a finished result waits in the output register. The numerator register is written through
// cfg_we and cfg_data; the user must write it only while idle, the block does not enforce it.
`default_nettype none
module pulse_period_speedometer
  import pps_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              cfg_we,
  input  wire  [NUM_W-1:0] cfg_data,
  input  wire              in_valid,
  output logic             in_stall,
  input  pps_in_t          in_data,
  output logic             out_valid,
  input  wire              out_stall,
  output pps_out_t         out_data
);

  pps_cmd_t    cmd;
  pps_status_t status;

  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pps_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
